@@ rtl/hps_pkg.sv @@
// hps_pkg: shared types and constants of the sensor compensation block
// no dependencies; imported by hps_mul, hps_div, the top level and the testbench

package hps_pkg;

  localparam int MUL_W = 36;  // bits of the serial multiplier operand
  localparam int DIV_W = 64;  // dividend bits walked by the serial divider

  typedef logic signed [63:0] word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MUL,
    ST_DIV
  } state_t;

  typedef enum logic [1:0] {
    UOP_ALU,
    UOP_MUL,
    UOP_DIV
  } uop_kind_t;

  localparam logic [1:0] OP_TEMP  = 2'd0;
  localparam logic [1:0] OP_PRESS = 2'd1;
  localparam logic [1:0] OP_HUM   = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  localparam logic [1:0] STS_OK   = 2'd0;
  localparam logic [1:0] STS_LOW  = 2'd1;
  localparam logic [1:0] STS_HIGH = 2'd2;
  localparam logic [1:0] STS_BAD  = 2'd3;

  localparam logic [2:0] CFG_TEMP    = 3'd0;
  localparam logic [2:0] CFG_PRESS_A = 3'd1;
  localparam logic [2:0] CFG_PRESS_B = 3'd2;
  localparam logic [2:0] CFG_PRESS_C = 3'd3;
  localparam logic [2:0] CFG_HUM     = 3'd4;

  localparam word_t TEMP_LO  = -64'sd4000;
  localparam word_t TEMP_HI  = 64'sd8500;
  localparam word_t PRESS_LO = 64'sd30000;
  localparam word_t PRESS_HI = 64'sd110000;
  localparam word_t HUM_LO   = 64'sd0;
  localparam word_t HUM_HI   = 64'sd10000;

endpackage

@@ rtl/humidity_pressure_temp_compensation.sv @@
// each product is formed in the bit-serial multiplier (36 operand bits), the
// pressure quotient in the restoring divider (64 dividend bits)
// one request at a time; the next is taken once the result sits in the output register
// reset (rst_n low, synchronous) clears control, calibration and fine temperature

module humidity_pressure_temp_compensation import hps_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [19:0] raw_sample
  input  logic [1:0]  in_tuser,   // [1:0] opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [17:0] value
  output logic [3:0]  out_tuser,  // [1:0] measure_kind, [3:2] status
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  typedef struct packed {
    uop_kind_t   kind;
    logic [2:0]  dst;
    word_t       res;
    word_t       ma;
    word_t       mb;
    logic        fine_we;
    logic        fin;
    logic        bad;
  } uop_t;

  localparam word_t P20 = 64'sd1 <<< 20;
  localparam word_t P21 = 64'sd1 <<< 21;
  localparam word_t P26 = 64'sd1 <<< 26;
  localparam word_t P28 = 64'sd1 <<< 28;
  localparam word_t P30 = 64'sd1 <<< 30;
  localparam word_t P32 = 64'sd1 <<< 32;
  localparam word_t P39 = 64'sd1 <<< 39;
  localparam word_t P41 = 64'sd1 <<< 41;
  localparam word_t P42 = 64'sd1 <<< 42;
  localparam word_t P52 = 64'sd1 <<< 52;
  localparam word_t P55 = 64'sd1 <<< 55;

  function automatic word_t sat(input word_t x, input word_t lim);
    if (x > lim) begin
      return lim;
    end else if (x < -lim) begin
      return -lim;
    end
    return x;
  endfunction

  state_t       state_r, state_nxt;
  logic [1:0]   op_r, op_nxt;
  logic [19:0]  adc_r, adc_nxt;
  logic [4:0]   step_r, step_nxt;
  word_t        w_r [6];
  word_t        w_nxt [6];
  logic signed [31:0] fine_r, fine_nxt;

  logic [47:0]  tcal_r;
  logic [63:0]  pa_r, pb_r, hcal_r;
  logic [15:0]  pc_r;

  logic         out_valid_r, out_valid_nxt;
  logic [1:0]   out_kind_r, out_kind_nxt;
  logic [17:0]  out_val_r, out_val_nxt;
  logic [1:0]   out_st_r, out_st_nxt;

  uop_t         u;
  word_t        adc64, hadc64, fine64, fs;
  word_t        t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
  word_t        h1, h2, h3, h4, h5, h6;
  word_t        tq, lo, hi;
  logic [17:0]  fin_val;
  logic [1:0]   fin_st;
  logic         mul_start, mul_done, div_start, div_done;
  logic         alu_wr, out_load, out_free, in_acc;
  word_t        mul_p, div_q;

  // calibration fields
  assign t1 = {48'd0, tcal_r[15:0]};
  assign t2 = {{48{tcal_r[31]}}, tcal_r[31:16]};
  assign t3 = {{48{tcal_r[47]}}, tcal_r[47:32]};
  assign p1 = {48'd0, pa_r[15:0]};
  assign p2 = {{48{pa_r[31]}}, pa_r[31:16]};
  assign p3 = {{48{pa_r[47]}}, pa_r[47:32]};
  assign p4 = {{48{pa_r[63]}}, pa_r[63:48]};
  assign p5 = {{48{pb_r[15]}}, pb_r[15:0]};
  assign p6 = {{48{pb_r[31]}}, pb_r[31:16]};
  assign p7 = {{48{pb_r[47]}}, pb_r[47:32]};
  assign p8 = {{48{pb_r[63]}}, pb_r[63:48]};
  assign p9 = {{48{pc_r[15]}}, pc_r};
  assign h1 = {56'd0, hcal_r[7:0]};
  assign h2 = {{48{hcal_r[23]}}, hcal_r[23:8]};
  assign h3 = {56'd0, hcal_r[31:24]};
  assign h4 = {{52{hcal_r[43]}}, hcal_r[43:32]};
  assign h5 = {{52{hcal_r[55]}}, hcal_r[55:44]};
  assign h6 = {{56{hcal_r[63]}}, hcal_r[63:56]};

  assign adc64  = {44'd0, adc_r};
  assign hadc64 = {48'd0, adc_r[15:0]};
  assign fine64 = {{32{fine_r[31]}}, fine_r};
  assign fs     = sat(fine64, P21);

  // step decode
  always_comb begin
    u      = '0;
    u.kind = UOP_ALU;
    case (op_r)
      OP_TEMP: begin
        case (step_r)
          5'd0: begin u.dst = 3'd0; u.res = adc64 - (t1 <<< 4); end
          5'd1: begin u.kind = UOP_MUL; u.dst = 3'd1; u.ma = w_r[0]; u.mb = t2; end
          5'd2: begin u.kind = UOP_MUL; u.dst = 3'd2; u.ma = w_r[0]; u.mb = w_r[0]; end
          5'd3: begin u.kind = UOP_MUL; u.dst = 3'd2; u.ma = w_r[2]; u.mb = t3; end
          5'd4: begin
            u.dst = 3'd0; u.res = (w_r[1] <<< 20) + w_r[2]; u.fine_we = 1'b1;
          end
          default: begin
            u.fin = 1'b1; u.res = ((w_r[0] <<< 2) + w_r[0] + P41) >>> 42;
          end
        endcase
      end
      OP_PRESS: begin
        case (step_r)
          5'd0: begin u.dst = 3'd0; u.res = fs - 64'sd128000; end
          5'd1: begin u.kind = UOP_MUL; u.dst = 3'd1; u.ma = w_r[0]; u.mb = w_r[0]; end
          5'd2: begin u.kind = UOP_MUL; u.dst = 3'd2; u.ma = w_r[1]; u.mb = p3; end
          5'd3: begin u.kind = UOP_MUL; u.dst = 3'd3; u.ma = w_r[0]; u.mb = p2; end
          5'd4: begin u.dst = 3'd2; u.res = (P55 + w_r[2] + (w_r[3] <<< 20)) >>> 25; end
          5'd5: begin u.kind = UOP_MUL; u.dst = 3'd2; u.ma = w_r[2]; u.mb = p1; end
          5'd6: begin
            // divisor not positive: minimum with invalid status
            u.dst = 3'd2; u.res = w_r[2] >>> 20;
            u.fin = (u.res <= 0); u.bad = u.fin;
          end
          5'd7: begin u.kind = UOP_MUL; u.dst = 3'd3; u.ma = w_r[1]; u.mb = p6; end
          5'd8: begin u.kind = UOP_MUL; u.dst = 3'd4; u.ma = w_r[0]; u.mb = p5; end
          5'd9: begin
            u.dst = 3'd3;
            u.res = (((P20 - adc64) <<< 31) - (w_r[3] + (w_r[4] <<< 17) + (p4 <<< 35))) >>> 23;
          end
          5'd10: begin
            u.kind = UOP_MUL; u.dst = 3'd3; u.ma = w_r[3]; u.mb = 64'sd400000;
          end
          5'd11: begin u.kind = UOP_DIV; u.dst = 3'd3; end
          5'd12: begin u.kind = UOP_MUL; u.dst = 3'd4; u.ma = w_r[3]; u.mb = p9; end
          5'd13: begin u.kind = UOP_MUL; u.dst = 3'd4; u.ma = w_r[4]; u.mb = w_r[3]; end
          5'd14: begin u.kind = UOP_MUL; u.dst = 3'd5; u.ma = w_r[3]; u.mb = p8; end
          default: begin
            u.fin = 1'b1;
            u.res = ((w_r[3] <<< 39) + w_r[4] + (w_r[5] <<< 20) + (p7 <<< 39) + P42) >>> 43;
          end
        endcase
      end
      OP_HUM: begin
        case (step_r)
          5'd0: begin u.dst = 3'd0; u.res = fs - 64'sd76800; end
          5'd1: begin u.kind = UOP_MUL; u.dst = 3'd1; u.ma = w_r[0]; u.mb = h5; end
          5'd2: begin u.dst = 3'd1; u.res = (hadc64 <<< 14) - (h4 <<< 20) - w_r[1]; end
          5'd3: begin u.kind = UOP_MUL; u.dst = 3'd1; u.ma = w_r[1]; u.mb = h2; end
          5'd4: begin u.dst = 3'd1; u.res = sat(w_r[1] >>> 10, P30); end
          5'd5: begin u.kind = UOP_MUL; u.dst = 3'd2; u.ma = w_r[0]; u.mb = h3; end
          5'd6: begin u.dst = 3'd2; u.res = P26 + w_r[2]; end
          5'd7: begin u.kind = UOP_MUL; u.dst = 3'd3; u.ma = w_r[0]; u.mb = h6; end
          5'd8: begin u.kind = UOP_MUL; u.dst = 3'd3; u.ma = w_r[3]; u.mb = w_r[2]; end
          5'd9: begin u.dst = 3'd3; u.res = (P52 + w_r[3]) >>> 30; end
          5'd10: begin u.kind = UOP_MUL; u.dst = 3'd3; u.ma = w_r[3]; u.mb = w_r[2]; end
          5'd11: begin u.dst = 3'd3; u.res = sat(w_r[3] >>> 18, P32); end
          5'd12: begin u.kind = UOP_MUL; u.dst = 3'd1; u.ma = w_r[1]; u.mb = w_r[3]; end
          5'd13: begin u.dst = 3'd1; u.res = sat(w_r[1] >>> 30, P28); end
          5'd14: begin u.kind = UOP_MUL; u.dst = 3'd2; u.ma = w_r[1]; u.mb = h1; end
          5'd15: begin u.dst = 3'd2; u.res = (P39 - w_r[2]) >>> 19; end
          5'd16: begin u.kind = UOP_MUL; u.dst = 3'd2; u.ma = w_r[2]; u.mb = w_r[1]; end
          5'd17: begin u.kind = UOP_MUL; u.dst = 3'd2; u.ma = w_r[2]; u.mb = 64'sd100; end
          default: begin u.fin = 1'b1; u.res = (w_r[2] + P39) >>> 40; end
        endcase
      end
      default: begin
        u.fin = 1'b1;
      end
    endcase
  end

  // truncate toward zero for the stored fine temperature
  always_comb begin
    tq = u.res >>> 34;
    if (u.res[63] && (|u.res[33:0])) begin
      tq = tq + 64'sd1;
    end
  end

  // range clamp of the finished value, or the minimum for an invalid pressure
  always_comb begin
    case (op_r)
      OP_TEMP: begin lo = TEMP_LO; hi = TEMP_HI; end
      OP_PRESS: begin lo = PRESS_LO; hi = PRESS_HI; end
      default: begin lo = HUM_LO; hi = HUM_HI; end
    endcase
    if (u.bad) begin
      fin_val = PRESS_LO[17:0];
      fin_st  = STS_BAD;
    end else if (u.res < lo) begin
      fin_val = lo[17:0];
      fin_st  = STS_LOW;
    end else if (u.res > hi) begin
      fin_val = hi[17:0];
      fin_st  = STS_HIGH;
    end else begin
      fin_val = u.res[17:0];
      fin_st  = STS_OK;
    end
  end

  hps_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (u.ma),
    .b     (u.mb[MUL_W-1:0]),
    .done  (mul_done),
    .p     (mul_p)
  );

  hps_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (w_r[3]),
    .den   (w_r[2][31:0]),
    .done  (div_done),
    .q     (div_q)
  );

  assign out_free = !out_valid_r || out_tready;
  assign in_acc   = in_tvalid && in_tready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid && (in_tuser != OP_NONE)) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (u.kind)
          UOP_MUL: state_nxt = ST_MUL;
          UOP_DIV: state_nxt = ST_DIV;
          default: begin
            if (u.fin && out_free) begin
              state_nxt = ST_IDLE;
            end
          end
        endcase
      end
      ST_MUL: begin
        if (mul_done) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_EXEC;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_tready = (state_r == ST_IDLE);
    mul_start = (state_r == ST_EXEC) && (u.kind == UOP_MUL);
    div_start = (state_r == ST_EXEC) && (u.kind == UOP_DIV);
    alu_wr    = (state_r == ST_EXEC) && (u.kind == UOP_ALU) && !u.fin;
    out_load  = (state_r == ST_EXEC) && (u.kind == UOP_ALU) && u.fin && out_free;
  end

  // datapath next values
  always_comb begin
    op_nxt   = op_r;
    adc_nxt  = adc_r;
    step_nxt = step_r;
    fine_nxt = fine_r;
    w_nxt    = w_r;
    if (in_acc) begin
      op_nxt   = in_tuser;
      adc_nxt  = in_tdata[19:0];
      step_nxt = '0;
    end
    if (alu_wr) begin
      w_nxt[u.dst] = u.res;
      step_nxt     = step_r + 1'b1;
      if (u.fine_we) begin
        fine_nxt = tq[31:0];
      end
    end
    if ((state_r == ST_MUL) && mul_done) begin
      w_nxt[u.dst] = mul_p;
      step_nxt     = step_r + 1'b1;
    end
    if ((state_r == ST_DIV) && div_done) begin
      w_nxt[u.dst] = sat(div_q, 64'sd1 <<< 22);
      step_nxt     = step_r + 1'b1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_kind_nxt  = out_kind_r;
    out_val_nxt   = out_val_r;
    out_st_nxt    = out_st_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_kind_nxt  = op_r;
      out_val_nxt   = fin_val;
      out_st_nxt    = fin_st;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      fine_r      <= '0;
      out_valid_r <= 1'b0;
      tcal_r      <= '0;
      pa_r        <= '0;
      pb_r        <= '0;
      pc_r        <= '0;
      hcal_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      fine_r      <= fine_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_TEMP:    tcal_r <= cfg_data[47:0];
          CFG_PRESS_A: pa_r   <= cfg_data;
          CFG_PRESS_B: pb_r   <= cfg_data;
          CFG_PRESS_C: pc_r   <= cfg_data[15:0];
          CFG_HUM:     hcal_r <= cfg_data;
          default: ;
        endcase
      end
    end
    op_r       <= op_nxt;
    adc_r      <= adc_nxt;
    w_r        <= w_nxt;
    out_kind_r <= out_kind_nxt;
    out_val_r  <= out_val_nxt;
    out_st_r   <= out_st_nxt;
  end

  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_val_r};
  assign out_tuser  = {out_st_r, out_kind_r};

  a_mul_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> state_r == ST_MUL)
    else $error("multiplier finished outside its wait state");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_DIV)
    else $error("divider finished outside its wait state");

  a_bad_only_press: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_st_r == STS_BAD)) |-> out_kind_r == OP_PRESS)
    else $error("invalid status on a non-pressure result");

  a_fine_from_temp: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(fine_r) |-> $past(op_r) == OP_TEMP)
    else $error("fine temperature changed outside a temperature request");

  a_unused_op_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser == OP_NONE)) |=> state_r == ST_IDLE)
    else $error("unused opcode started a computation");

endmodule

@@ rtl/hps_mul.sv @@
// hps_mul: shift-add multiplier, one bit of the signed b operand per cycle
// depends on hps_pkg (word_t, MUL_W)

module hps_mul import hps_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  word_t                   a,
  input  logic signed [MUL_W-1:0] b,
  output logic                    done,
  output word_t                   p
);

  localparam int CW = $clog2(MUL_W);

  word_t            acc_r, acc_nxt;
  word_t            a_r, a_nxt;
  logic [MUL_W-1:0] b_r, b_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;

  always_comb begin
    acc_nxt  = acc_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      acc_nxt  = '0;
      a_nxt    = a;
      b_nxt    = b;
      cnt_nxt  = CW'(MUL_W - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // top bit of b carries negative weight
      if (b_r[0]) begin
        acc_nxt = (cnt_r == '0) ? acc_r - a_r : acc_r + a_r;
      end
      a_nxt   = a_r <<< 1;
      b_nxt   = b_r >> 1;
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
  end

  assign done = done_r;
  assign p    = acc_r;

endmodule

@@ rtl/hps_div.sv @@
// hps_div: restoring divider, one quotient bit per cycle, floor rounding
// depends on hps_pkg (word_t, DIV_W); divisor must be positive

module hps_div import hps_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  word_t       num,
  input  logic [31:0] den,
  output logic        done,
  output word_t       q
);

  localparam int CW = $clog2(DIV_W);

  logic [63:0]   qr_r, qr_nxt;
  logic [31:0]   rem_r, rem_nxt;
  logic [31:0]   den_r, den_nxt;
  logic          neg_r, neg_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [32:0]   trial;

  always_comb begin
    qr_nxt   = qr_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, qr_r[63]};
    if (start) begin
      qr_nxt   = num[63] ? 64'(-num) : 64'(num);
      rem_nxt  = '0;
      den_nxt  = den;
      neg_nxt  = num[63];
      cnt_nxt  = CW'(DIV_W - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = 32'(trial - {1'b0, den_r});
        qr_nxt  = {qr_r[62:0], 1'b1};
      end else begin
        rem_nxt = trial[31:0];
        qr_nxt  = {qr_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    qr_r  <= qr_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
  end

  // negative dividend: -q, one lower when a remainder is left
  always_comb begin
    if (!neg_r) begin
      q = word_t'(qr_r);
    end else if (|rem_r) begin
      q = word_t'(~qr_r);
    end else begin
      q = word_t'(-qr_r);
    end
  end

  assign done = done_r;

endmodule

@@ dv/humidity_pressure_temp_compensation_test.sv @@
// testbench for humidity_pressure_temp_compensation: drives raw sensor requests and
// calibration writes, predicts every compensated reading in 64-bit fixed point
// depends on rtl/hps_pkg.sv and rtl/humidity_pressure_temp_compensation.sv
`timescale 1ns / 1ps

module humidity_pressure_temp_compensation_test;
  import hps_pkg::*;

  typedef struct packed {
    logic [1:0]  op;
    logic [19:0] raw;
  } sample_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [17:0] value;
    logic [1:0]  status;
  } reading_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic [3:0]  out_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  sample_t  pending_samples[$];
  reading_t expected_readings[$];

  // calibration and fine temperature as the block should hold them
  logic [63:0] cal_temp, cal_pa, cal_pb, cal_pc, cal_hum;
  int          fine_t;

  int  src_idle_pct = 0, snk_idle_pct = 0;
  int  sink_hold = 0;
  int  errors = 0, n_checked = 0, n_cfg = 0;
  int  status_seen[4];
  longint cycles = 0;

  humidity_pressure_temp_compensation u_dut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  always #4 clk = ~clk;

  function automatic longint p2(int n);
    return longint'(1) << n;
  endfunction

  function automatic longint sat(longint x, longint lim);
    if (x > lim) return lim;
    if (x < -lim) return -lim;
    return x;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi, output logic [1:0] st);
    st = STS_OK;
    if (v < lo) begin
      st = STS_LOW;
      return lo;
    end
    if (v > hi) begin
      st = STS_HIGH;
      return hi;
    end
    return v;
  endfunction

  function automatic longint s16(logic [63:0] w, int pos);
    logic signed [15:0] f;
    f = w[pos +: 16];
    return longint'(f);
  endfunction

  // compute the compensated reading for one request and queue it; an unused opcode queues none
  function automatic void compensate(logic [1:0] op, logic [19:0] raw);
    longint adc, d, n, a, k, dr, m, mq, pq, t, q, v;
    longint b, x, uq, y, z, wq, r, f, prod;
    longint h2, h4, h5, h6;
    logic signed [11:0] f12;
    logic signed [7:0]  f8;
    logic [1:0] st;
    reading_t rd;
    adc = longint'(raw);
    st = STS_OK;
    case (op)
      OP_TEMP: begin
        d = adc - 16 * longint'(cal_temp[15:0]);
        n = d * s16(cal_temp, 16) * p2(20) + d * d * s16(cal_temp, 32);
        fine_t = int'(n / p2(34));
        v = clamp((5 * n + p2(41)) >>> 42, TEMP_LO, TEMP_HI, st);
      end
      OP_PRESS: begin
        a = sat(longint'(fine_t), p2(21)) - 128000;
        k = p2(55) + s16(cal_pa, 32) * a * a + s16(cal_pa, 16) * a * p2(20);
        dr = (longint'(cal_pa[15:0]) * (k >>> 25)) >>> 20;
        if (dr <= 0) begin
          v = 30000;
          st = STS_BAD;
        end else begin
          m = (p2(20) - adc) * p2(31)
              - (s16(cal_pb, 16) * a * a + s16(cal_pb, 0) * a * p2(17) + s16(cal_pa, 48) * p2(35));
          mq = m >>> 23;
          q = (mq * 400000) / dr;
          if ((mq * 400000) % dr != 0 && mq * 400000 < 0) q = q - 1;
          pq = sat(q, p2(22));
          t = pq * p2(39) + s16(cal_pc, 0) * pq * pq + s16(cal_pb, 48) * pq * p2(20)
              + s16(cal_pb, 32) * p2(39);
          v = clamp((t + p2(42)) >>> 43, PRESS_LO, PRESS_HI, st);
        end
      end
      OP_HUM: begin
        h2 = s16(cal_hum, 8);
        f12 = cal_hum[43:32];
        h4 = longint'(f12);
        f12 = cal_hum[55:44];
        h5 = longint'(f12);
        f8 = cal_hum[63:56];
        h6 = longint'(f8);
        b = sat(longint'(fine_t), p2(21)) - 76800;
        x = longint'(raw[15:0]) * p2(14) - h4 * p2(20) - h5 * b;
        uq = sat((x * h2) >>> 10, p2(30));
        y = p2(26) + longint'(cal_hum[31:24]) * b;
        z = p2(52) + h6 * b * y;
        wq = sat((y * (z >>> 30)) >>> 18, p2(32));
        r = sat((uq * wq) >>> 30, p2(28));
        f = p2(39) - longint'(cal_hum[7:0]) * r;
        prod = r * (f >>> 19);
        v = clamp((prod * 100 + p2(39)) >>> 40, HUM_LO, HUM_HI, st);
      end
      default: return;  // unused opcode: no reading
    endcase
    rd.kind = op;
    rd.value = v[17:0];
    rd.status = st;
    expected_readings.push_back(rd);
  endfunction

  // request driver
  always @(posedge clk) begin
    sample_t s;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) compensate(in_tuser, in_tdata[19:0]);
      if (!in_tvalid || in_tready) begin
        if (pending_samples.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
          s = pending_samples.pop_front();
          in_tvalid <= 1'b1;
          in_tuser <= s.op;
          in_tdata <= {4'b0, s.raw};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk) begin
    reading_t want, got;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = {out_tuser[1:0], out_tdata[17:0], out_tuser[3:2]};
        if (expected_readings.size() == 0) begin
          $display("%0t: unexpected reading kind=%0d value=%0d status=%0d", $time,
                   got.kind, $signed(got.value), got.status);
          errors++;
        end else begin
          want = expected_readings.pop_front();
          n_checked++;
          status_seen[want.status]++;
          if (got !== want) begin
            $display("%0t: mismatch expected kind=%0d value=%0d status=%0d, actual kind=%0d value=%0d status=%0d",
                     $time, want.kind, $signed(want.value), want.status,
                     got.kind, $signed(got.value), got.status);
            errors++;
          end
        end
      end
      if (sink_hold > 0) begin
        sink_hold <= sink_hold - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("timeout with %0d readings outstanding", expected_readings.size());
      $display("FAIL");
      $finish;
    end
  end

  task automatic write_cal(logic [2:0] idx, logic [63:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_TEMP:    cal_temp = {16'b0, data[47:0]};
      CFG_PRESS_A: cal_pa = data;
      CFG_PRESS_B: cal_pb = data;
      CFG_PRESS_C: cal_pc = {48'b0, data[15:0]};
      CFG_HUM:     cal_hum = data;
      default: ;
    endcase
    n_cfg++;
  endtask

  task automatic drain();
    while (pending_samples.size() > 0 || in_tvalid || expected_readings.size() > 0)
      @(posedge clk);
    repeat (600) @(posedge clk);  // an unused opcode starts no computation and queues no reading
  endtask

  task automatic load_typical(bit jitter);
    logic [15:0] j;
    j = jitter ? 16'($urandom_range(0, 255)) : 16'd0;
    write_cal(CFG_TEMP, {16'hfc18 + j, 16'd26435 - j, 16'd27504 + j});
    write_cal(CFG_PRESS_A, {16'd2855 + j, 16'd3024, 16'hd443 + j, 16'd36477 - j});
    write_cal(CFG_PRESS_B, {16'hc6f8, 16'd15500 + j, 16'hfff9, 16'd140 + j});
    write_cal(CFG_PRESS_C, {$urandom, 16'd6000 + j});
    write_cal(CFG_HUM, {8'd30, 12'd50, 12'd313, 8'(j), 16'd362 + j, 8'd75});
  endtask

  function automatic sample_t pick_sample();
    sample_t s;
    int r;
    r = $urandom_range(99);
    s.op = (r < 4) ? OP_NONE : r < 36 ? OP_TEMP : r < 68 ? OP_PRESS : OP_HUM;
    if ($urandom_range(1)) begin
      s.raw = 20'($urandom);
    end else begin
      case (s.op)
        OP_TEMP:  s.raw = 20'd519888 + 20'($urandom_range(0, 65535)) - 20'd32768;
        OP_PRESS: s.raw = 20'd415148 + 20'($urandom_range(0, 65535)) - 20'd32768;
        default:  s.raw = 20'($urandom_range(20000, 45000));
      endcase
    end
    return s;
  endfunction

  task automatic push_random(int count);
    repeat (count) pending_samples.push_back(pick_sample());
  endtask

  initial begin
    cal_temp = '0; cal_pa = '0; cal_pb = '0; cal_pc = '0; cal_hum = '0;
    fine_t = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset calibration: zero divisor makes pressure invalid
    pending_samples.push_back('{OP_TEMP, 20'd0});
    pending_samples.push_back('{OP_PRESS, 20'd415148});
    pending_samples.push_back('{OP_HUM, 20'd30000});
    drain();

    // directed: field extremes with datasheet-like calibration
    load_typical(0);
    pending_samples.push_back('{OP_TEMP, 20'd519888});
    pending_samples.push_back('{OP_PRESS, 20'd415148});
    pending_samples.push_back('{OP_HUM, 20'd30000});
    pending_samples.push_back('{OP_HUM, 20'hf7530});  // upper bits ignored
    pending_samples.push_back('{OP_NONE, 20'hfffff});
    pending_samples.push_back('{OP_PRESS, 20'd0});
    pending_samples.push_back('{OP_PRESS, 20'hfffff});
    pending_samples.push_back('{OP_HUM, 20'd0});
    pending_samples.push_back('{OP_HUM, 20'hffff});
    pending_samples.push_back('{OP_TEMP, 20'hfffff});  // hot clamp
    pending_samples.push_back('{OP_PRESS, 20'd415148});
    pending_samples.push_back('{OP_HUM, 20'd30000});
    pending_samples.push_back('{OP_TEMP, 20'd0});      // cold clamp
    pending_samples.push_back('{OP_PRESS, 20'd415148});
    pending_samples.push_back('{OP_HUM, 20'd45000});
    drain();

    // phase one: sender idles lightly, receiver heavily; pause midway
    src_idle_pct = 13; snk_idle_pct = 46;
    load_typical(1);
    push_random(70);
    drain();
    push_random(80);
    drain();

    // phase two: random calibration words, long receiver hold-off
    src_idle_pct = 46; snk_idle_pct = 13;
    write_cal(CFG_TEMP, {$urandom, $urandom});
    write_cal(CFG_PRESS_A, {$urandom, $urandom});
    write_cal(CFG_PRESS_B, {$urandom, $urandom});
    write_cal(CFG_PRESS_C, {$urandom, $urandom});
    write_cal(CFG_HUM, {$urandom, $urandom});
    push_random(150);
    repeat (20) @(posedge clk);
    sink_hold <= 3000;
    drain();

    // phase three: all-ones, all-zeros and sign-bit corners, no idling
    src_idle_pct = 0; snk_idle_pct = 0;
    write_cal(CFG_TEMP, '1);
    write_cal(CFG_PRESS_A, '1);
    write_cal(CFG_PRESS_B, '0);
    write_cal(CFG_PRESS_C, 64'h7fff);
    write_cal(CFG_HUM, '1);
    push_random(60);
    drain();
    load_typical(1);
    push_random(90);
    drain();
    write_cal(CFG_PRESS_C, 64'h8000);
    write_cal(CFG_HUM, 64'h7f7ff7ff_ff7fffff);
    push_random(150);
    drain();

    $display("checked %0d readings after %0d calibration writes", n_checked, n_cfg);
    $display("status counts: ok %0d, low %0d, high %0d, invalid %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/hps_pkg.sv
rtl/hps_mul.sv
rtl/hps_div.sv
rtl/humidity_pressure_temp_compensation.sv
dv/humidity_pressure_temp_compensation_test.sv
